### rtl/core/smbs_pkg.sv
// Shared request codes and result record for the SPI master byte shifter.
`timescale 1ns / 1ps

package smbs_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_NONE     = 3'd0;
  localparam logic [2:0] REQ_TRANSFER = 3'd1;
  localparam logic [2:0] REQ_SELECT   = 3'd2;
  localparam logic [2:0] REQ_DESELECT = 3'd3;
  localparam logic [2:0] REQ_SET_RST  = 3'd4;

  // Delay register value after reset.
  localparam logic [7:0] DELAY_RESET = 8'd10;

  // One result record, produced for every tick.
  typedef struct packed {
    logic       sck_out;
    logic       mosi_out;
    logic       cs_n_out;
    logic       rst_n_out;
    logic       busy_res;
    logic       accepted;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       data_ready;
  } result_t;

endpackage

### rtl/core/smbs_if.sv
// Channel interfaces: tick input, result output and delay configuration.
`timescale 1ns / 1ps

interface smbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] tx_byte;
  logic       reset_high;
  logic       miso_level;
  logic       drdy_level;

  modport source (output valid, req_type, tx_byte, reset_high, miso_level, drdy_level,
                  input ready);
  modport sink (input valid, req_type, tx_byte, reset_high, miso_level, drdy_level,
                output ready);
endinterface

interface smbs_out_if;
  logic       valid;
  logic       ready;
  logic       sck_out;
  logic       mosi_out;
  logic       cs_n_out;
  logic       rst_n_out;
  logic       busy_res;
  logic       accepted;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       data_ready;

  modport source (output valid, sck_out, mosi_out, cs_n_out, rst_n_out, busy_res,
                  accepted, rx_valid, rx_byte, data_ready, input ready);
  modport sink (input valid, sck_out, mosi_out, cs_n_out, rst_n_out, busy_res,
                accepted, rx_valid, rx_byte, data_ready, output ready);
endinterface

interface smbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/spi_master_byte_shifter.sv
// Top level of the tick-driven SPI master byte shifter (mode 0, MSB first).
//
//  Channel  | Role  | Handshake    | Carries
//  ---------+-------+--------------+-----------------------------------------------
//  in_ch    | sink  | valid/ready  | req_type, tx_byte, reset_high, miso, drdy
//  out_ch   | source| valid/ready  | pin levels, busy, accepted, rx byte, data_ready
//  cfg      | sink  | valid/ready  | delay_ticks write data
//
// Every tick transfer produces one result transfer; one tick is taken per clock
// cycle, set by the single result register after the sequencer's next-state logic.
// A new tick is taken while the result register is empty or is being drained.
// Reset deselects the chip, releases the device reset, idles SCK and MOSI low and
// sets the delay to 10. A stall on the result side holds the sequencer still.
`timescale 1ns / 1ps

module spi_master_byte_shifter #(
  parameter int BITS_PER_WORD = 8
) (
  input logic       clk,
  input logic       rst,
  smbs_in_if.sink   in_ch,
  smbs_out_if.source out_ch,
  smbs_cfg_if.sink  cfg
);
  import smbs_pkg::*;

  logic       delay_ticks;
  logic [7:0] delay_reg;
  logic       in_fire;
  logic       out_valid;
  result_t    out_res;
  result_t    step_res;

  // Configuration writes are always taken.
  assign cfg.ready   = 1'b1;
  assign delay_ticks = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_reg <= DELAY_RESET;
    end else if (delay_ticks) begin
      delay_reg <= cfg.data;
    end
  end

  // Input is taken whenever the result register can move on.
  assign in_ch.ready = ~out_valid | out_ch.ready;
  assign in_fire     = in_ch.valid & in_ch.ready;

  smbs_engine #(
    .BITS_PER_WORD(BITS_PER_WORD)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .advance    (in_fire),
    .delay_ticks(delay_reg),
    .req_type   (in_ch.req_type),
    .tx_byte    (in_ch.tx_byte),
    .reset_high (in_ch.reset_high),
    .miso_level (in_ch.miso_level),
    .drdy_level (in_ch.drdy_level),
    .result     (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res <= step_res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sck_out    = out_res.sck_out;
  assign out_ch.mosi_out   = out_res.mosi_out;
  assign out_ch.cs_n_out   = out_res.cs_n_out;
  assign out_ch.rst_n_out  = out_res.rst_n_out;
  assign out_ch.busy_res   = out_res.busy_res;
  assign out_ch.accepted   = out_res.accepted;
  assign out_ch.rx_valid   = out_res.rx_valid;
  assign out_ch.rx_byte    = out_res.rx_byte;
  assign out_ch.data_ready = out_res.data_ready;

endmodule

### rtl/core/smbs_engine.sv
// Bit-bang sequencer: pin levels, delay counter and shift registers, one step per tick.
`timescale 1ns / 1ps

module smbs_engine #(
  parameter int BITS_PER_WORD = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       delay_ticks,
  input  logic [2:0]       req_type,
  input  logic [7:0]       tx_byte,
  input  logic             reset_high,
  input  logic             miso_level,
  input  logic             drdy_level,
  output smbs_pkg::result_t result
);
  import smbs_pkg::*;

  localparam int W     = BITS_PER_WORD;
  localparam int IDX_W = (W > 1) ? $clog2(W) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(W - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SETUP, PH_HIGH, PH_LOW, PH_SEL
  } phase_t;

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] bit_index, bit_index_next;
  logic [7:0]       wait_count, wait_count_next;
  logic [W-1:0]     tx_shift, tx_shift_next;
  logic [W-1:0]     rx_shift, rx_shift_next;
  logic             sck, sck_next;
  logic             mosi, mosi_next;
  logic             cs_n, cs_n_next;
  logic             rst_n, rst_n_next;
  logic             accepted;
  logic             rx_valid;
  logic [7:0]       rx_out;
  logic [7:0]       delay_eff;
  logic [W-1:0]     tx_load;

  // A zero delay behaves as a single tick.
  assign delay_eff = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;
  assign tx_load   = W'(tx_byte);

  // Next state for one tick: count down, step the bit phase, or take a request.
  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    wait_count_next = wait_count;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    sck_next        = sck;
    mosi_next       = mosi;
    cs_n_next       = cs_n;
    rst_n_next      = rst_n;
    accepted        = 1'b0;
    rx_valid        = 1'b0;
    rx_out          = 8'd0;
    if (phase != PH_IDLE) begin
      if (wait_count > 8'd1) begin
        wait_count_next = wait_count - 8'd1;
      end else begin
        wait_count_next = 8'd0;
        case (phase)
          PH_SETUP: begin
            sck_next        = 1'b1;
            phase_next      = PH_HIGH;
            wait_count_next = delay_eff;
          end
          PH_HIGH: begin
            sck_next        = 1'b0;
            phase_next      = PH_LOW;
            wait_count_next = delay_eff;
          end
          PH_LOW: begin
            rx_shift_next = (rx_shift << 1) | W'(miso_level);
            tx_shift_next = tx_shift << 1;
            if (bit_index == LAST_IDX) begin
              rx_valid   = 1'b1;
              rx_out     = 8'(rx_shift_next);
              phase_next = PH_IDLE;
            end else begin
              bit_index_next  = bit_index + IDX_W'(1);
              mosi_next       = tx_shift_next[W-1];
              phase_next      = PH_SETUP;
              wait_count_next = delay_eff;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end else begin
      case (req_type)
        REQ_TRANSFER: begin
          tx_shift_next   = tx_load;
          rx_shift_next   = '0;
          bit_index_next  = '0;
          mosi_next       = tx_load[W-1];
          phase_next      = PH_SETUP;
          wait_count_next = delay_eff;
          accepted        = 1'b1;
        end
        REQ_SELECT: begin
          cs_n_next       = 1'b0;
          phase_next      = PH_SEL;
          wait_count_next = delay_eff;
          accepted        = 1'b1;
        end
        REQ_DESELECT: begin
          cs_n_next       = 1'b1;
          phase_next      = PH_SEL;
          wait_count_next = delay_eff;
          accepted        = 1'b1;
        end
        REQ_SET_RST: begin
          rst_n_next = reset_high;
          accepted   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result shows the pin levels after this tick's update.
  always_comb begin
    result.sck_out    = sck_next;
    result.mosi_out   = mosi_next;
    result.cs_n_out   = cs_n_next;
    result.rst_n_out  = rst_n_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.accepted   = accepted;
    result.rx_valid   = rx_valid;
    result.rx_byte    = rx_out;
    result.data_ready = ~drdy_level;
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      wait_count <= 8'd0;
      tx_shift   <= '0;
      rx_shift   <= '0;
      sck        <= 1'b0;
      mosi       <= 1'b0;
      cs_n       <= 1'b1;
      rst_n      <= 1'b1;
    end else if (advance) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      wait_count <= wait_count_next;
      tx_shift   <= tx_shift_next;
      rx_shift   <= rx_shift_next;
      sck        <= sck_next;
      mosi       <= mosi_next;
      cs_n       <= cs_n_next;
      rst_n      <= rst_n_next;
    end
  end

endmodule
